[sv/assert_macros.svh]
// assert_macros.svh: assertion macros shared by the checker files.
// No dependencies; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define S5T_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define S5T_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/s5t_pkg.sv]
// s5t_pkg: types, codes and constants of the S5TIME codec.
// No dependencies; used by s5time_codec and s5t_chk.
package s5t_pkg;

    // Operation codes carried in the kind field
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // Time base codes, bits 13:12 of the S5TIME word
    typedef enum logic [1:0] {
        BASE_10MS  = 2'd0,
        BASE_100MS = 2'd1,
        BASE_1S    = 2'd2,
        BASE_10S   = 2'd3
    } base_code_t;

    // Largest duration each base can hold (999 * base)
    localparam logic [23:0] LIMIT_10MS  = 24'd9990;
    localparam logic [23:0] LIMIT_100MS = 24'd99900;
    localparam logic [23:0] LIMIT_1S    = 24'd999000;

    // Exact reciprocals for 24-bit dividends: ceil(2^k / d), k = 24 + ceil(log2 d)
    localparam logic [24:0] RECIP_DIV10    = 25'd26843546;
    localparam logic [24:0] RECIP_DIV100   = 25'd21474837;
    localparam logic [24:0] RECIP_DIV1000  = 25'd17179870;
    localparam logic [24:0] RECIP_DIV10000 = 25'd27487791;
    localparam int SHIFT_DIV10    = 28;
    localparam int SHIFT_DIV100   = 31;
    localparam int SHIFT_DIV1000  = 34;
    localparam int SHIFT_DIV10000 = 38;

    // Narrow reciprocals: q < 4096 by 100, r < 100 by 10, s < 3600 by 60
    localparam logic [12:0] RECIP_Q100  = 13'd5243;
    localparam int          SHIFT_Q100  = 19;
    localparam logic [7:0]  RECIP_R10   = 8'd205;
    localparam int          SHIFT_R10   = 11;
    localparam logic [11:0] RECIP_S60   = 12'd2185;
    localparam int          SHIFT_S60   = 17;

    localparam logic [3:0]  DIGIT_MAX     = 4'd9;
    localparam logic [13:0] SEC_PER_HOUR  = 14'd3600;
    localparam logic [13:0] SEC_TWO_HOURS = 14'd7200;

    // Input beat
    typedef struct packed {
        logic        kind;
        logic [23:0] duration_ms;
        logic [15:0] s5t_code;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [15:0] coded_word;
        logic [23:0] decoded_ms;
        logic [1:0]  part_hours;
        logic [5:0]  part_minutes;
        logic [5:0]  part_seconds;
        logic [9:0]  part_millis;
        logic        bcd_error;
    } res_t;

    // Pipeline stage 1: quotient and unpacked digits
    typedef struct packed {
        logic        kind;
        base_code_t  enc_code;
        logic [11:0] enc_q;
        logic        bcd_err;
        base_code_t  dec_code;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [3:0]  d0;
        logic [9:0]  dec_n;
    } s1_t;

    // Pipeline stage 2: hundreds digit, remainders, hour split
    typedef struct packed {
        logic        kind;
        base_code_t  enc_code;
        logic [3:0]  enc_hund;
        logic [6:0]  enc_rem;
        logic        bcd_err;
        logic [23:0] dec_v;
        logic [1:0]  dec_hours;
        logic [11:0] dec_rem_s;
        logic [9:0]  dec_millis;
    } s2_t;

endpackage

[sv/s5time_codec.sv]
// s5time_codec: converts ms durations to S5TIME words and back.
// Depends on s5t_pkg.
//
//   channel  | valid     | ready     | payload
//   ---------+-----------+-----------+---------------
//   command  | cmd_valid | cmd_ready | cmd (cmd_t)
//   result   | res_valid | res_ready | res (res_t)
//
// One beat in per cycle while the result register is not stalled, one result per beat; each
// beat passes the input register, two internal stages and the result register. The encode
// divide is one 24x25 reciprocal multiply; the digit and minute splits each take one
// narrow multiply per stage.
// A stalled result register freezes the whole pipe; cmd_ready is low only then.
// Reset clears the stage valid bits; payload registers are not reset.
module s5time_codec
    import s5t_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic advance;

    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, res_vld_reg;
    cmd_t cmd_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    res_t res_reg, res_next;

    // Stage 1 temporaries
    logic [49:0] enc_prod;
    logic [3:0]  dig2, dig1, dig0;

    // Stage 2 temporaries
    logic [24:0] hund_prod;
    logic [5:0]  hund_full;
    logic [13:0] sec_total;

    // Stage 3 temporaries
    logic [14:0] tens_prod;
    logic [3:0]  tens, ones;
    logic [23:0] min_prod;
    logic [5:0]  minutes, seconds;

    // Whole pipe moves unless a result is waiting
    assign advance   = !res_vld_reg || res_ready;
    assign cmd_ready = advance;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // Stage 1: base choice and reciprocal divide; BCD unpack and check
    always_comb
    begin
        s1_next      = '0;
        s1_next.kind = cmd_reg.kind;
        if (cmd_reg.duration_ms <= LIMIT_10MS)
        begin
            s1_next.enc_code = BASE_10MS;
        end
        else if (cmd_reg.duration_ms <= LIMIT_100MS)
        begin
            s1_next.enc_code = BASE_100MS;
        end
        else if (cmd_reg.duration_ms <= LIMIT_1S)
        begin
            s1_next.enc_code = BASE_1S;
        end
        else
        begin
            s1_next.enc_code = BASE_10S;
        end

        enc_prod = '0;
        case (s1_next.enc_code)
            BASE_10MS:
            begin
                enc_prod = 50'(cmd_reg.duration_ms) * 50'(RECIP_DIV10);
                s1_next.enc_q = enc_prod[SHIFT_DIV10 +: 12];
            end
            BASE_100MS:
            begin
                enc_prod = 50'(cmd_reg.duration_ms) * 50'(RECIP_DIV100);
                s1_next.enc_q = enc_prod[SHIFT_DIV100 +: 12];
            end
            BASE_1S:
            begin
                enc_prod = 50'(cmd_reg.duration_ms) * 50'(RECIP_DIV1000);
                s1_next.enc_q = enc_prod[SHIFT_DIV1000 +: 12];
            end
            default:
            begin
                enc_prod = 50'(cmd_reg.duration_ms) * 50'(RECIP_DIV10000);
                s1_next.enc_q = enc_prod[SHIFT_DIV10000 +: 12];
            end
        endcase

        dig2 = cmd_reg.s5t_code[11:8];
        dig1 = cmd_reg.s5t_code[7:4];
        dig0 = cmd_reg.s5t_code[3:0];
        s1_next.bcd_err  = (dig2 > DIGIT_MAX) || (dig1 > DIGIT_MAX) || (dig0 > DIGIT_MAX);
        s1_next.dec_code = base_code_t'(cmd_reg.s5t_code[13:12]);
        s1_next.d2       = dig2;
        s1_next.d1       = dig1;
        s1_next.d0       = dig0;
        s1_next.dec_n    = 10'(dig2) * 10'd100 + 10'(dig1) * 10'd10 + 10'(dig0);
    end

    // Stage 2: hundreds digit with saturation; scaled value and hour split
    always_comb
    begin
        s2_next          = '0;
        s2_next.kind     = s1_reg.kind;
        s2_next.enc_code = s1_reg.enc_code;
        s2_next.bcd_err  = s1_reg.bcd_err;

        hund_prod        = 25'(s1_reg.enc_q) * 25'(RECIP_Q100);
        hund_full        = hund_prod[SHIFT_Q100 +: 6];
        s2_next.enc_rem  = 7'(s1_reg.enc_q - 12'(hund_full) * 12'd100);
        s2_next.enc_hund = (hund_full > 6'(DIGIT_MAX)) ? DIGIT_MAX : hund_full[3:0];

        // seconds total and leftover ms, read straight off the digits
        sec_total = '0;
        case (s1_reg.dec_code)
            BASE_10MS:
            begin
                sec_total          = 14'(s1_reg.d2);
                s2_next.dec_millis = 10'(s1_reg.d1) * 10'd100 + 10'(s1_reg.d0) * 10'd10;
                s2_next.dec_v      = 24'(s1_reg.dec_n) * 24'd10;
            end
            BASE_100MS:
            begin
                sec_total          = 14'(s1_reg.d2) * 14'd10 + 14'(s1_reg.d1);
                s2_next.dec_millis = 10'(s1_reg.d0) * 10'd100;
                s2_next.dec_v      = 24'(s1_reg.dec_n) * 24'd100;
            end
            BASE_1S:
            begin
                sec_total     = 14'(s1_reg.dec_n);
                s2_next.dec_v = 24'(s1_reg.dec_n) * 24'd1000;
            end
            default:
            begin
                sec_total     = 14'(s1_reg.dec_n) * 14'd10;
                s2_next.dec_v = 24'(s1_reg.dec_n) * 24'd10000;
            end
        endcase

        if (sec_total >= SEC_TWO_HOURS)
        begin
            s2_next.dec_hours = 2'd2;
            s2_next.dec_rem_s = 12'(sec_total - SEC_TWO_HOURS);
        end
        else if (sec_total >= SEC_PER_HOUR)
        begin
            s2_next.dec_hours = 2'd1;
            s2_next.dec_rem_s = 12'(sec_total - SEC_PER_HOUR);
        end
        else
        begin
            s2_next.dec_hours = 2'd0;
            s2_next.dec_rem_s = 12'(sec_total);
        end
    end

    // Stage 3: tens/ones digits, minutes/seconds, result packing
    always_comb
    begin
        tens_prod = 15'(s2_reg.enc_rem) * 15'(RECIP_R10);
        tens      = tens_prod[SHIFT_R10 +: 4];
        ones      = 4'(s2_reg.enc_rem - 7'(tens) * 7'd10);

        min_prod  = 24'(s2_reg.dec_rem_s) * 24'(RECIP_S60);
        minutes   = min_prod[SHIFT_S60 +: 6];
        seconds   = 6'(s2_reg.dec_rem_s - 12'(minutes) * 12'd60);

        res_next = '0;
        if (s2_reg.kind == KIND_ENCODE)
        begin
            res_next.coded_word = {2'b00, s2_reg.enc_code, s2_reg.enc_hund, tens, ones};
        end
        else if (s2_reg.bcd_err)
        begin
            res_next.bcd_error = 1'b1;
        end
        else
        begin
            res_next.decoded_ms   = s2_reg.dec_v;
            res_next.part_hours   = s2_reg.dec_hours;
            res_next.part_minutes = minutes;
            res_next.part_seconds = seconds;
            res_next.part_millis  = s2_reg.dec_millis;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_vld_reg  <= cmd_valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            res_vld_reg <= s2_vld_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            res_reg <= res_next;
        end
    end

endmodule

[sv/s5t_chk.sv]
// s5t_chk: port-level assertions for s5time_codec, bound into s5time_codec.
// Depends on s5t_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s5t_chk
    import s5t_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A stalled result beat stays put
    `S5T_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res), "result beat dropped or changed while stalled")

    // With no result pending the codec always takes a new beat
    `S5T_ASSERT(a_cmd_ready, clk, rst_n, !res_valid |-> cmd_ready, "command stalled with empty result register")

    // A result is either an encode or a decode, never both
    `S5T_ASSERT(a_one_kind, clk, rst_n, res_valid && res.coded_word != 16'd0 |-> res.decoded_ms == 24'd0 && !res.bcd_error, "encode and decode fields both set")

    // A BCD error clears all decoded fields
    `S5T_ASSERT(a_err_zero, clk, rst_n, res_valid && res.bcd_error |-> res.decoded_ms == 24'd0 && res.part_hours == 2'd0 && res.part_minutes == 6'd0 && res.part_seconds == 6'd0 && res.part_millis == 10'd0, "decoded fields set on BCD error")

    // No result right after reset release
    `S5T_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !res_valid, "result valid after reset")

endmodule

bind s5time_codec s5t_chk u_s5t_chk (.*);
